/* hdl/amf_pkg.sv */
// Package for the air mouse motion framer: constants, register indexes,
// configuration and frame summary types. No dependencies.
`default_nettype none

package amf_pkg;

   localparam int AXES        = 3;
   localparam int FRAME_HALF  = 7;
   localparam int FRAME_LEN   = 14;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [6:0]  MOTION_THRESHOLD_RESET = 7'd3;
   localparam logic [7:0]  FREEZE_TICKS_RESET     = 8'd40;
   localparam logic [15:0] IDLE_LIMIT_RESET       = 16'd3000;
   localparam logic [7:0]  HEADER_BYTE_RESET      = 8'hA5;
   localparam logic [15:0] RECAL_KEY_MASK_RESET   = 16'h2000;

   // register indexes
   localparam logic [2:0] CSR_MOTION_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_FREEZE_TICKS     = 3'd1;
   localparam logic [2:0] CSR_IDLE_LIMIT       = 3'd2;
   localparam logic [2:0] CSR_HEADER_BYTE      = 3'd3;
   localparam logic [2:0] CSR_RECAL_KEY_MASK   = 3'd4;

   // byte positions within one half of the frame
   localparam logic [2:0] POS_HEADER_A = 3'd0;
   localparam logic [2:0] POS_HEADER_B = 3'd1;
   localparam logic [2:0] POS_NEG_Y    = 3'd2;
   localparam logic [2:0] POS_NEG_Z    = 3'd3;
   localparam logic [2:0] POS_KEY_HI   = 3'd4;
   localparam logic [2:0] POS_KEY_LO   = 3'd5;
   localparam logic [2:0] POS_SUM      = 3'd6;

   localparam logic [3:0] HALF_IDX = 4'(FRAME_HALF);
   localparam logic [3:0] LAST_IDX = 4'(FRAME_LEN - 1);

   typedef struct packed {
      logic [6:0]  motion_threshold;
      logic [7:0]  freeze_ticks;
      logic [15:0] idle_limit;
      logic [7:0]  header_byte;
      logic [15:0] recal_key_mask;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  header_byte;
      logic [7:0]  neg_y;
      logic [7:0]  neg_z;
      logic [15:0] keys;
      logic [7:0]  sum;
      logic        sleep_request;
      logic        recalibrate;
   } frame_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

endpackage

`default_nettype wire

/* hdl/amf_if.sv */
// Handshake channels of the framer: sample input, frame byte output and
// register writes. Depends on nothing.
`default_nettype none

interface amf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] angle_x;
   logic signed [15:0] angle_y;
   logic signed [15:0] angle_z;
   logic        [15:0] key_state;
   modport source (output valid, angle_x, angle_y, angle_z, key_state, input ready);
   modport sink   (input valid, angle_x, angle_y, angle_z, key_state, output ready);
endinterface

interface amf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;
   logic       sleep_request;
   logic       recalibrate;
   modport source (output valid, frame_byte, last_byte, sleep_request, recalibrate,
                   input ready);
   modport sink   (input valid, frame_byte, last_byte, sleep_request, recalibrate,
                   output ready);
endinterface

interface amf_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/amf_front.sv */
// Front end: takes samples, works out deltas, activity, freeze and idle state
// and builds a frame summary for the queue. Uses amf_pkg and amf_req_if.
`default_nettype none

module amf_front (
   input  wire logic               clock,
   input  wire logic               reset,
   amf_req_if.sink                 req_bus,
   input  wire amf_pkg::cfg_type   cfg,
   input  wire amf_pkg::qstat_type qstat,
   output logic                    push,
   output amf_pkg::frame_type      push_frame
);

   logic signed [15:0] prev_angle_ff [amf_pkg::AXES];
   logic               primed_ff;
   logic [15:0]        prev_keys_ff;
   logic               freeze_active_ff, freeze_active_in;
   logic [7:0]         freeze_count_ff, freeze_count_in;
   logic [15:0]        idle_count_ff, idle_count_in;

   logic signed [15:0] cur [amf_pkg::AXES];
   logic signed [16:0] diff [amf_pkg::AXES];
   logic signed [16:0] quot [amf_pkg::AXES];
   logic signed [7:0]  delta [amf_pkg::AXES];
   logic        [7:0]  mag [amf_pkg::AXES];
   logic               motion, active, zero_deltas, sleep, fire;
   logic [15:0]        keys;
   logic [7:0]         neg_y, neg_z;

   assign req_bus.ready = !qstat.full;
   assign fire          = req_bus.valid && req_bus.ready;
   assign push          = fire && primed_ff;
   assign keys          = req_bus.key_state;

   always_comb begin
      cur[0] = req_bus.angle_x;
      cur[1] = req_bus.angle_y;
      cur[2] = req_bus.angle_z;
      motion = 1'b0;
      for (int i = 0; i < amf_pkg::AXES; i++) begin
         diff[i] = 17'(cur[i]) - 17'(prev_angle_ff[i]);
         // divide by four, rounding toward zero
         quot[i] = (diff[i] + (diff[i][16] ? 17'sd3 : 17'sd0)) >>> 2;
         if (quot[i] > 17'sd127) begin
            delta[i] = 8'sd127;
         end else if (quot[i] < -17'sd128) begin
            delta[i] = -8'sd128;
         end else begin
            delta[i] = quot[i][7:0];
         end
         mag[i] = delta[i][7] ? 8'(-delta[i]) : delta[i];
         if (mag[i] > {1'b0, cfg.motion_threshold}) begin
            motion = 1'b1;
         end
      end
   end

   always_comb begin
      active           = motion || (keys != 16'd0) || (prev_keys_ff != 16'd0);
      freeze_active_in = freeze_active_ff;
      freeze_count_in  = freeze_count_ff;
      zero_deltas      = 1'b0;
      if (active) begin
         if (keys != 16'd0) begin
            freeze_active_in = 1'b1;
         end else if (!freeze_active_ff) begin
            freeze_count_in = cfg.freeze_ticks;
         end
         idle_count_in = '0;
      end else begin
         idle_count_in = idle_count_ff + 16'd1;
      end
      if (freeze_active_in) begin
         if (freeze_count_in != 8'd0) begin
            freeze_count_in = freeze_count_in - 8'd1;
            zero_deltas     = 1'b1;
         end else begin
            freeze_active_in = 1'b0;
         end
      end
      sleep = idle_count_in >= cfg.idle_limit;
      if (sleep) begin
         idle_count_in = '0;
      end
      neg_y = zero_deltas ? 8'd0 : 8'(-delta[1]);
      neg_z = zero_deltas ? 8'd0 : 8'(-delta[2]);
      push_frame.header_byte   = cfg.header_byte;
      push_frame.neg_y         = neg_y;
      push_frame.neg_z         = neg_z;
      push_frame.keys          = keys;
      push_frame.sum           = cfg.header_byte + cfg.header_byte + neg_y + neg_z
                                 + keys[15:8] + keys[7:0];
      push_frame.sleep_request = sleep;
      push_frame.recalibrate   = (keys & cfg.recal_key_mask) != 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < amf_pkg::AXES; i++) begin
            prev_angle_ff[i] <= '0;
         end
         primed_ff        <= 1'b0;
         prev_keys_ff     <= '0;
         freeze_active_ff <= 1'b0;
         freeze_count_ff  <= amf_pkg::FREEZE_TICKS_RESET;
         idle_count_ff    <= '0;
      end else if (fire) begin
         for (int i = 0; i < amf_pkg::AXES; i++) begin
            prev_angle_ff[i] <= cur[i];
         end
         primed_ff <= 1'b1;
         if (primed_ff) begin
            if (active) begin
               prev_keys_ff <= keys;
            end
            freeze_active_ff <= freeze_active_in;
            freeze_count_ff  <= freeze_count_in;
            idle_count_ff    <= idle_count_in;
         end
      end
   end

   a_sleep_clears_idle: assert property (@(posedge clock) disable iff (reset)
      (push && push_frame.sleep_request) |=> (idle_count_ff == 16'd0))
      else $error("idle count not cleared after sleep request");

endmodule

`default_nettype wire

/* hdl/amf_queue.sv */
// Short frame summary queue between front and back end.
// Uses amf_pkg.
`default_nettype none

module amf_queue #(
   parameter int DEPTH = amf_pkg::QUEUE_DEPTH   // 2 or more
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire amf_pkg::frame_type push_frame,
   input  wire logic               pop,
   output amf_pkg::frame_type      head_frame,
   output amf_pkg::qstat_type      qstat
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   amf_pkg::frame_type entry_ff [DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]    count_ff;

   assign head_frame      = entry_ff[rd_ptr_ff];
   assign qstat.full      = count_ff == CntW'(DEPTH);
   assign qstat.not_empty = count_ff != '0;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CntW'(DEPTH)))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");

endmodule

`default_nettype wire

/* hdl/amf_back.sv */
// Back end: takes a frame summary from the queue and sends its seven bytes
// twice, one byte per item. Uses amf_pkg and amf_rsp_if.
`default_nettype none

module amf_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire amf_pkg::qstat_type qstat,
   input  wire amf_pkg::frame_type head_frame,
   output logic                    pop,
   amf_rsp_if.source               rsp_bus
);

   amf_pkg::frame_type frame_ff;
   logic               busy_ff;
   logic [3:0]         idx_ff;
   logic [3:0]         half_idx;
   logic [2:0]         pos;
   logic               taken, at_last;

   assign at_last = idx_ff == amf_pkg::LAST_IDX;
   assign taken   = busy_ff && rsp_bus.ready;
   assign pop     = qstat.not_empty && (!busy_ff || (taken && at_last));

   assign half_idx = (idx_ff >= amf_pkg::HALF_IDX) ? idx_ff - amf_pkg::HALF_IDX : idx_ff;
   assign pos      = half_idx[2:0];

   always_comb begin
      case (pos)
         amf_pkg::POS_HEADER_A: rsp_bus.frame_byte = frame_ff.header_byte;
         amf_pkg::POS_HEADER_B: rsp_bus.frame_byte = frame_ff.header_byte;
         amf_pkg::POS_NEG_Y:    rsp_bus.frame_byte = frame_ff.neg_y;
         amf_pkg::POS_NEG_Z:    rsp_bus.frame_byte = frame_ff.neg_z;
         amf_pkg::POS_KEY_HI:   rsp_bus.frame_byte = frame_ff.keys[15:8];
         amf_pkg::POS_KEY_LO:   rsp_bus.frame_byte = frame_ff.keys[7:0];
         amf_pkg::POS_SUM:      rsp_bus.frame_byte = frame_ff.sum;
         default:               rsp_bus.frame_byte = '0;
      endcase
   end

   assign rsp_bus.valid         = busy_ff;
   assign rsp_bus.last_byte     = at_last;
   assign rsp_bus.sleep_request = frame_ff.sleep_request;
   assign rsp_bus.recalibrate   = frame_ff.recalibrate;

   always_ff @(posedge clock) begin
      if (pop) begin
         frame_ff <= head_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (taken) begin
         if (at_last) begin
            busy_ff <= 1'b0;
            idx_ff  <= '0;
         end else begin
            idx_ff <= idx_ff + 4'd1;
         end
      end
   end

   a_idx_in_frame: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= amf_pkg::LAST_IDX))
      else $error("byte index beyond frame");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !rsp_bus.ready) |=> (busy_ff && $stable(idx_ff)))
      else $error("byte index moved while stalled");

endmodule

`default_nettype wire

/* hdl/air_mouse_motion_framer.sv */
// Motion framer top level. A sample's summary is registered in the summary queue
// and then in the back end's frame register before its first byte is offered;
// it yields 14 byte items, one per cycle when the sink is ready, so the sustained
// sample rate is set by the byte serialiser in the back end. The front end takes
// one sample per cycle until the QUEUE_DEPTH summary queue fills; the first sample
// only primes. Synchronous reset restores register defaults; no clearing pass.
`default_nettype none

module air_mouse_motion_framer #(
   parameter int QUEUE_DEPTH = amf_pkg::QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   amf_req_if.sink   req_bus,
   amf_rsp_if.source rsp_bus,
   amf_csr_if.sink   csr_bus
);

   amf_pkg::cfg_type   cfg_ff;
   amf_pkg::qstat_type qstat;
   amf_pkg::frame_type push_frame, head_frame;
   logic               push, pop;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motion_threshold <= amf_pkg::MOTION_THRESHOLD_RESET;
         cfg_ff.freeze_ticks     <= amf_pkg::FREEZE_TICKS_RESET;
         cfg_ff.idle_limit       <= amf_pkg::IDLE_LIMIT_RESET;
         cfg_ff.header_byte      <= amf_pkg::HEADER_BYTE_RESET;
         cfg_ff.recal_key_mask   <= amf_pkg::RECAL_KEY_MASK_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            amf_pkg::CSR_MOTION_THRESHOLD: cfg_ff.motion_threshold <= csr_bus.data[6:0];
            amf_pkg::CSR_FREEZE_TICKS:     cfg_ff.freeze_ticks     <= csr_bus.data[7:0];
            amf_pkg::CSR_IDLE_LIMIT:       cfg_ff.idle_limit       <= csr_bus.data;
            amf_pkg::CSR_HEADER_BYTE:      cfg_ff.header_byte      <= csr_bus.data[7:0];
            amf_pkg::CSR_RECAL_KEY_MASK:   cfg_ff.recal_key_mask   <= csr_bus.data;
            default: ;  // unknown index: ignored
         endcase
      end
   end

   amf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .qstat      (qstat),
      .push       (push),
      .push_frame (push_frame)
   );

   amf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head_frame (head_frame),
      .qstat      (qstat)
   );

   amf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head_frame (head_frame),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

/* test/air_mouse_motion_framer_test.sv */
// Self-checking testbench for the air mouse motion framer: drives samples and
// register writes, predicts every frame byte and checks the bytes in order.
// Depends on amf_pkg, the channel interfaces in amf_if.sv and the framer top.
`default_nettype none

module air_mouse_motion_framer_test;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_GAP       = 18;
   localparam int RANDOM_ITEMS  = 450;
   localparam int PHASES        = 5;
   localparam int MAX_REPORTS   = 200;
   localparam int LONG_HOLD     = 400;

   // indexes with no register behind them
   localparam logic [2:0] CSR_SPARE_A = 3'd5;
   localparam logic [2:0] CSR_SPARE_B = 3'd6;
   localparam logic [2:0] CSR_SPARE_C = 3'd7;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
      logic       sleep_request;
      logic       recalibrate;
   } frame_item_type;

   logic clock = 1'b0;
   logic reset;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   amf_req_if req_bus ();
   amf_rsp_if rsp_bus ();
   amf_csr_if csr_bus ();

   air_mouse_motion_framer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // framer state as predicted
   amf_pkg::cfg_type   cfg_model;
   logic signed [15:0] prev_angle [amf_pkg::AXES];
   logic               primed;
   logic [15:0]        prev_keys;
   logic               freeze_on;
   logic [7:0]         freeze_left;
   logic [15:0]        idle_samples;

   frame_item_type expected_bytes [$];
   int          mismatch_count = 0;
   int          bytes_checked  = 0;
   int          tx_max_gap     = MAX_GAP;
   int          rx_max_gap     = MAX_GAP;
   int          rx_hold_cycles = 0;
   int          last_angle [amf_pkg::AXES];
   int          cycle_count    = 0;

   function automatic void reset_model();
      cfg_model = '{motion_threshold: amf_pkg::MOTION_THRESHOLD_RESET,
                    freeze_ticks:     amf_pkg::FREEZE_TICKS_RESET,
                    idle_limit:       amf_pkg::IDLE_LIMIT_RESET,
                    header_byte:      amf_pkg::HEADER_BYTE_RESET,
                    recal_key_mask:   amf_pkg::RECAL_KEY_MASK_RESET};
      for (int i = 0; i < amf_pkg::AXES; i++) begin
         prev_angle[i] = '0;
         last_angle[i] = 0;
      end
      primed       = 1'b0;
      prev_keys    = '0;
      freeze_on    = 1'b0;
      freeze_left  = amf_pkg::FREEZE_TICKS_RESET;
      idle_samples = '0;
   endfunction

   function automatic void predict_frame(input logic [15:0] ax, input logic [15:0] ay,
                                         input logic [15:0] az, input logic [15:0] keys);
      logic signed [15:0] cur_angle [amf_pkg::AXES];
      int                 delta [amf_pkg::AXES];
      int                 mag;
      logic               active;
      logic               sleep_req;
      logic               recal;
      logic [7:0]         half [amf_pkg::FRAME_HALF];
      logic [7:0]         sum;
      frame_item_type     item;
      cur_angle[0] = $signed(ax);
      cur_angle[1] = $signed(ay);
      cur_angle[2] = $signed(az);
      if (!primed) begin
         // first sample only loads the angles; keys are not looked at
         for (int i = 0; i < amf_pkg::AXES; i++) prev_angle[i] = cur_angle[i];
         primed = 1'b1;
         return;
      end
      recal  = (keys & cfg_model.recal_key_mask) != '0;
      active = 1'b0;
      for (int i = 0; i < amf_pkg::AXES; i++) begin
         delta[i] = (int'(cur_angle[i]) - int'(prev_angle[i])) / 4;
         if (delta[i] > 127) delta[i] = 127;
         if (delta[i] < -128) delta[i] = -128;
         prev_angle[i] = cur_angle[i];
         mag = (delta[i] < 0) ? -delta[i] : delta[i];
         if (mag > int'(cfg_model.motion_threshold)) active = 1'b1;
      end
      if (keys != '0 || prev_keys != '0) active = 1'b1;
      if (active) begin
         if (keys != '0) begin
            freeze_on = 1'b1;
         end else if (!freeze_on) begin
            freeze_left = cfg_model.freeze_ticks;
         end
         prev_keys    = keys;
         idle_samples = '0;
      end else begin
         idle_samples = idle_samples + 16'd1;
      end
      if (freeze_on) begin
         if (freeze_left != '0) begin
            freeze_left = freeze_left - 8'd1;
            for (int i = 0; i < amf_pkg::AXES; i++) delta[i] = 0;
         end else begin
            freeze_on = 1'b0;
         end
      end
      sleep_req = 1'b0;
      if (idle_samples >= cfg_model.idle_limit) begin
         sleep_req    = 1'b1;
         idle_samples = '0;
      end
      half[amf_pkg::POS_HEADER_A] = cfg_model.header_byte;
      half[amf_pkg::POS_HEADER_B] = cfg_model.header_byte;
      half[amf_pkg::POS_NEG_Y]    = 8'(-delta[1]);
      half[amf_pkg::POS_NEG_Z]    = 8'(-delta[2]);
      half[amf_pkg::POS_KEY_HI]   = keys[15:8];
      half[amf_pkg::POS_KEY_LO]   = keys[7:0];
      sum = '0;
      for (int i = 0; i < amf_pkg::FRAME_HALF - 1; i++) sum = sum + half[i];
      half[amf_pkg::POS_SUM] = sum;
      for (int k = 0; k < amf_pkg::FRAME_LEN; k++) begin
         item.frame_byte    = half[k % amf_pkg::FRAME_HALF];
         item.last_byte     = (k == amf_pkg::FRAME_LEN - 1);
         item.sleep_request = sleep_req;
         item.recalibrate   = recal;
         expected_bytes.push_back(item);
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at byte %0d: %s", bytes_checked, what);
   endtask

   // valid is left high after acceptance so back-to-back items need no toggle
   task automatic send_sample(input int ax, input int ay, input int az, input int keys);
      int                 gap;
      logic signed [15:0] trunc [amf_pkg::AXES];
      gap = $urandom_range(0, tx_max_gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      trunc[0] = 16'(ax);
      trunc[1] = 16'(ay);
      trunc[2] = 16'(az);
      req_bus.valid     <= 1'b1;
      req_bus.angle_x   <= trunc[0];
      req_bus.angle_y   <= trunc[1];
      req_bus.angle_z   <= trunc[2];
      req_bus.key_state <= 16'(keys);
      do @(posedge clock); while (!req_bus.ready);
      predict_frame(trunc[0], trunc[1], trunc[2], 16'(keys));
      for (int i = 0; i < amf_pkg::AXES; i++) last_angle[i] = int'(trunc[i]);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      // a priming item gives no bytes, so allow for one still in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (index)
         amf_pkg::CSR_MOTION_THRESHOLD: cfg_model.motion_threshold = data[6:0];
         amf_pkg::CSR_FREEZE_TICKS:     cfg_model.freeze_ticks     = data[7:0];
         amf_pkg::CSR_IDLE_LIMIT:       cfg_model.idle_limit       = data;
         amf_pkg::CSR_HEADER_BYTE:      cfg_model.header_byte      = data[7:0];
         amf_pkg::CSR_RECAL_KEY_MASK:   cfg_model.recal_key_mask   = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_random_sample();
      int a [amf_pkg::AXES];
      int keys;
      int kind;
      int span;
      kind = $urandom_range(0, 99);
      span = ($urandom_range(0, 3) == 0) ? 600 : 4 * (int'(cfg_model.motion_threshold) + 2);
      for (int i = 0; i < amf_pkg::AXES; i++) begin
         if (kind < 75) a[i] = last_angle[i] + int'($urandom_range(0, 2 * span)) - span;
         else if (kind < 88) a[i] = int'($urandom_range(0, 36000)) - 18000;
         else a[i] = int'($urandom);
      end
      if (kind >= 88) keys = int'($urandom_range(0, 65535));
      else if ($urandom_range(0, 9) == 0) keys = 1 << $urandom_range(0, 15);
      else keys = 0;
      send_sample(a[0], a[1], a[2], keys);
   endtask

   task automatic test_priming_and_extremes();
      // priming item carries keys that must be ignored
      send_sample(-18000, 18000, -18000, 'hFFFF);
      send_sample(18000, -18000, 18000, 'h0000);
      send_sample(-32768, 32767, -32768, 'h0000);
      // y goes to -128, whose negation wraps to 0x80
      send_sample(32767, -32768, 32767, 'h0000);
      // small negative and positive differences truncate toward zero
      send_sample(32760, -32755, 32767, 'h0000);
      send_sample(32760, -32768, 32754, 'h0000);
   endtask

   task automatic test_freeze_window();
      wait_drained();
      write_reg(amf_pkg::CSR_FREEZE_TICKS, 16'hFF03);
      send_sample(2000, 2000, 2000, 'h0000);
      send_sample(4000, 4000, 4000, 'h2000);
      send_sample(6000, 6000, 6000, 'h0000);
      send_sample(8000, 8000, 8000, 'h0000);
      send_sample(10000, 10000, 10000, 'h0000);
      send_sample(12000, 12000, 12000, 'h0000);
      wait_drained();
      write_reg(amf_pkg::CSR_FREEZE_TICKS, 16'h0000);
      send_sample(10000, 10000, 10000, 'h0000);
      send_sample(8000, 8000, 8000, 'hFFFF);
   endtask

   task automatic test_sleep_request();
      wait_drained();
      write_reg(amf_pkg::CSR_IDLE_LIMIT, 16'd1);
      send_sample(8000, 8000, 8000, 'h0000);
      send_sample(8000, 8000, 8000, 'h0000);
      wait_drained();
      write_reg(amf_pkg::CSR_IDLE_LIMIT, 16'd0);
      send_sample(8000, 8000, 8000, 'h0000);
      wait_drained();
      write_reg(amf_pkg::CSR_IDLE_LIMIT, 16'd3);
      repeat (4) send_sample(8000, 8001, 7999, 'h0000);
   endtask

   task automatic test_register_writes();
      wait_drained();
      write_reg(amf_pkg::CSR_MOTION_THRESHOLD, 16'hFF80);
      write_reg(amf_pkg::CSR_HEADER_BYTE, 16'hFF00);
      write_reg(amf_pkg::CSR_RECAL_KEY_MASK, 16'hFFFF);
      send_sample(8004, 8000, 8000, 'h0001);
      wait_drained();
      write_reg(amf_pkg::CSR_MOTION_THRESHOLD, 16'h007F);
      write_reg(amf_pkg::CSR_HEADER_BYTE, 16'hFFFF);
      write_reg(amf_pkg::CSR_RECAL_KEY_MASK, 16'h0000);
      send_sample(8404, 7600, 8400, 'h8000);
      wait_drained();
      write_reg(CSR_SPARE_A, 16'hFFFF);
      write_reg(CSR_SPARE_B, 16'hFFFF);
      write_reg(CSR_SPARE_C, 16'hFFFF);
      send_sample(8404, 7200, 8800, 'h0000);
   endtask

   task automatic test_backpressure();
      wait_drained();
      tx_max_gap     = 0;
      rx_hold_cycles = LONG_HOLD;
      repeat (12) send_random_sample();
      tx_max_gap = MAX_GAP;
      // sender holds back until every byte has come out
      wait_drained();
      repeat (4) send_random_sample();
   endtask

   task automatic test_random_samples();
      int          thr;
      int          ticks;
      int          limit;
      logic [7:0]  hdr;
      logic [15:0] mask;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               thr = 0; ticks = 0; limit = 1; hdr = 8'h00; mask = 16'hFFFF;
            end
            1: begin
               thr = 127; ticks = 255; limit = 16'hFFFF; hdr = 8'hFF; mask = 16'h0000;
            end
            default: begin
               thr   = $urandom_range(0, 12);
               ticks = $urandom_range(0, 12);
               limit = $urandom_range(1, 15);
               hdr   = 8'($urandom);
               mask  = 16'($urandom);
            end
         endcase
         // upper data bits are random: only the register's width counts
         write_reg(amf_pkg::CSR_MOTION_THRESHOLD, {9'($urandom), 7'(thr)});
         write_reg(amf_pkg::CSR_FREEZE_TICKS, {8'($urandom), 8'(ticks)});
         write_reg(amf_pkg::CSR_IDLE_LIMIT, 16'(limit));
         write_reg(amf_pkg::CSR_HEADER_BYTE, {8'($urandom), hdr});
         write_reg(amf_pkg::CSR_RECAL_KEY_MASK, mask);
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if (n % 30 == 0) begin
               tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
               rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            end
            send_random_sample();
         end
      end
      tx_max_gap = MAX_GAP;
      rx_max_gap = MAX_GAP;
   endtask

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.angle_x   <= '0;
      req_bus.angle_y   <= '0;
      req_bus.angle_z   <= '0;
      req_bus.key_state <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= amf_pkg::CSR_MOTION_THRESHOLD;
      csr_bus.data      <= '0;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_priming_and_extremes();
      test_freeze_window();
      test_sleep_request();
      test_register_writes();
      test_backpressure();
      test_random_samples();
      wait_drained();
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("air_mouse_motion_framer_test: PASS");
      end else begin
         $display("air_mouse_motion_framer_test: FAIL");
      end
      $finish;
   end

   // result side: random hold-offs per item, plus a long one on request
   initial begin
      int pause;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            pause          = rx_hold_cycles;
            rx_hold_cycles = 0;
         end else begin
            pause = $urandom_range(0, rx_max_gap);
         end
         if (pause > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   always @(posedge clock) begin
      frame_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("byte %02h with nothing expected", rsp_bus.frame_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_bus.frame_byte !== want.frame_byte)
               report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                         rsp_bus.frame_byte, want.frame_byte));
            if (rsp_bus.last_byte !== want.last_byte)
               report_mismatch($sformatf("last_byte %b, expected %b",
                                         rsp_bus.last_byte, want.last_byte));
            if (rsp_bus.sleep_request !== want.sleep_request)
               report_mismatch($sformatf("sleep_request %b, expected %b",
                                         rsp_bus.sleep_request, want.sleep_request));
            if (rsp_bus.recalibrate !== want.recalibrate)
               report_mismatch($sformatf("recalibrate %b, expected %b",
                                         rsp_bus.recalibrate, want.recalibrate));
         end
         bytes_checked++;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("air_mouse_motion_framer_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
hdl/amf_pkg.sv
hdl/amf_if.sv
hdl/amf_front.sv
hdl/amf_queue.sv
hdl/amf_back.sv
hdl/air_mouse_motion_framer.sv
test/air_mouse_motion_framer_test.sv
